// ===== design/ofr_pkg.sv =====
package ofr_pkg;

  // flag bits of one base
  localparam logic [3:0] FL_START = 4'b0001;
  localparam logic [3:0] FL_END   = 4'b0010;
  localparam logic [3:0] FL_OCC5  = 4'b0100;
  localparam logic [3:0] FL_OCC3  = 4'b1000;

  // item modes
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_CUT    = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_OCCLUDED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_SCAN_END = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_OCC5   = 3'd0;
  localparam logic [2:0] REG_OCC3   = 3'd1;
  localparam logic [2:0] REG_TARGET = 3'd2;
  localparam logic [2:0] REG_MIN    = 3'd3;
  localparam logic [2:0] REG_MAX    = 3'd4;

  // fixed constants
  localparam int unsigned MIN_TRANSCRIPT = 20;
  localparam int unsigned BIN_CLAMP      = 10000;
  localparam int unsigned BIN_RECIP      = 52429; // ceil(2^19 / 10)
  localparam int unsigned BIN_SHIFT      = 19;
  localparam int unsigned LEN_W          = 17;
  localparam int unsigned BIN_W          = 10;
  localparam int unsigned CLAMP_W        = 14;
  localparam int unsigned MUL_B_W        = 18;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] transcript_len;
    logic [10:0] copies;
    logic [15:0] site_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] total_bases;
    logic [16:0] fragment_count;
    logic        target_reached;
    logic [16:0] fragment_len;
    logic [1:0]  length_class;
    logic [9:0]  bin_index;
  } out_item_t;

endpackage

// ===== design/occluded_random_fragmenter.sv =====
// Occluded random fragmenter. An item is taken when start is high and busy is
// low; busy then stays high until the result, which is shown for one cycle
// with done_o and cannot be held off. Every item ends with the mean-length
// test on the shared multiplier, in S_FIN and then S_FIN_WAIT. An append
// checks the size, compares the fill plus transcript_len * copies against
// the store and then writes each base of every copy; a short transcript,
// no copies or a full store skip the writes. A cut refused by range goes
// straight to the end; otherwise it reads the site, stops if occluded, and
// else walks the 5' run and then the 3' run, either of which may stop early.
// A scan stops at once when the pointer is at the end; mode 3 goes to the end.
// The flag memory with one write port and one registered read port sets
// these walks: each base walked in the 5' run needs a read state and a
// decide state, each base in the 3' run or a scan also a step state. The flag
// memory has no reset; bases are written by append before they are read.
module occluded_random_fragmenter import ofr_pkg::*; #(
  parameter int unsigned STORE_BASES = 65536,
  parameter int unsigned HIST_BINS   = 1001
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o,
  input  logic      cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned AW    = $clog2(STORE_BASES);
  localparam int unsigned CNT_W = $clog2(STORE_BASES + 1);
  localparam int unsigned CW    = CNT_W + 1;
  localparam int unsigned MW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int unsigned PW    = MW + MUL_B_W;
  localparam int unsigned BIN_CAP = (HIST_BINS - 1 < 1000) ? HIST_BINS - 1 : 1000;

  typedef enum logic [4:0] {
    S_IDLE, S_APP_START, S_APP_CMP, S_APP_WR,
    S_CUT_RD, S_CUT_CHK, S_FWD_RD, S_FWD_CHK, S_BK_START, S_BK_STEP,
    S_BK_RD, S_BK_CHK,
    S_SC_START, S_SC_RD0, S_SC_CHK0, S_SC_TEST, S_SC_RD, S_SC_CHK,
    S_BIN_MUL, S_BIN_WAIT, S_FIN, S_FIN_WAIT
  } state_e;

  state_e state_q;

  // configuration
  logic [7:0]  occ5_q, occ3_q;
  logic [16:0] target_q, min_q, max_q;

  // architectural state
  logic [CNT_W-1:0] used_q, frag_q, sp_q;

  // sequencer working registers
  logic [CNT_W-1:0] pos_q, len_q;
  logic [7:0]       i_q;
  logic [16:0]      k_q, tlen_q;
  logic [10:0]      c_q, copies_q;
  logic [15:0]      site_q;

  // result registers
  logic [2:0]       status_q;
  logic [1:0]       cls_q;
  logic [BIN_W-1:0] bin_q;
  logic             reached_q, done_q;

  // memory write port, registered
  logic          we_q;
  logic [AW-1:0] wa_q;
  logic [3:0]    wd_q;
  logic [3:0]    rd_data;

  // multiplier operands
  logic [MW-1:0]      mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PW-1:0]      prod;

  ofr_flag_ram #(.DEPTH(STORE_BASES), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_q),
    .waddr_i (wa_q),
    .wdata_i (wd_q),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  ofr_mul #(.AW(MW)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // operand selection for the shared multiplier
  logic [CLAMP_W-1:0] clamp;
  always_comb begin
    clamp = (MW'(len_q) > MW'(BIN_CLAMP)) ? CLAMP_W'(BIN_CLAMP) : CLAMP_W'(len_q);
    case (state_q)
      S_APP_START: begin
        mul_a = MW'(tlen_q);
        mul_b = MUL_B_W'(copies_q);
      end
      S_BIN_MUL: begin
        mul_a = MW'(clamp);
        mul_b = MUL_B_W'(BIN_RECIP);
      end
      default: begin
        mul_a = MW'(frag_q);
        mul_b = MUL_B_W'(target_q) + MUL_B_W'(1);
      end
    endcase
  end

  // flags of the base being appended
  logic [3:0] app_flags;
  always_comb begin
    app_flags = 4'b0000;
    if (k_q == 17'd0) begin
      app_flags = app_flags | FL_START;
    end else if (k_q == tlen_q - 17'd1) begin
      app_flags = app_flags | FL_END;
    end
    if (k_q < 17'(occ5_q)) begin
      app_flags = app_flags | FL_OCC5;
    end
    if (18'(k_q) + 18'(occ3_q) >= 18'(tlen_q)) begin
      app_flags = app_flags | FL_OCC3;
    end
  end

  logic [BIN_W-1:0] bin_raw;
  assign bin_raw = prod[BIN_SHIFT +: BIN_W];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ5_q    <= '0;
      occ3_q    <= '0;
      target_q  <= 17'd200;
      min_q     <= '0;
      max_q     <= 17'h10000;
      used_q    <= '0;
      frag_q    <= '0;
      sp_q      <= '0;
      done_q    <= 1'b0;
      we_q      <= 1'b0;
      status_q  <= ST_OK;
      cls_q     <= '0;
      bin_q     <= '0;
      reached_q <= 1'b0;
      pos_q     <= '0;
      len_q     <= '0;
      i_q       <= '0;
      k_q       <= '0;
      c_q       <= '0;
      tlen_q    <= '0;
      copies_q  <= '0;
      site_q    <= '0;
      wa_q      <= '0;
      wd_q      <= '0;
    end else begin
      done_q <= 1'b0;
      we_q   <= 1'b0;

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_OCC5:   occ5_q   <= cfg_data_i[7:0];
          REG_OCC3:   occ3_q   <= cfg_data_i[7:0];
          REG_TARGET: target_q <= cfg_data_i;
          REG_MIN:    min_q    <= cfg_data_i;
          REG_MAX:    max_q    <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            status_q <= ST_OK;
            len_q    <= '0;
            cls_q    <= '0;
            bin_q    <= '0;
            tlen_q   <= item_i.transcript_len;
            copies_q <= item_i.copies;
            site_q   <= item_i.site_offset;
            unique case (item_i.mode)
              MODE_APPEND: state_q <= S_APP_START;
              MODE_CUT: begin
                pos_q <= CNT_W'(item_i.site_offset);
                if (item_i.site_offset == 16'd0 ||
                    item_i.site_offset < 16'(item_i.site_offset == 16'd0 ? 8'd0 : occ5_q) ||
                    CW'(item_i.site_offset) + CW'(occ3_q) >= CW'(used_q)) begin
                  status_q <= ST_RANGE;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_CUT_RD;
                end
              end
              MODE_SCAN: state_q <= S_SC_START;
              default:   state_q <= S_FIN;
            endcase
          end
        end

        // append: size check then one base per cycle
        S_APP_START: begin
          if (tlen_q < 17'(MIN_TRANSCRIPT) || copies_q == 11'd0) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_APP_CMP;
          end
        end
        S_APP_CMP: begin
          k_q <= '0;
          c_q <= '0;
          if ((PW+1)'(used_q) + (PW+1)'(prod) > (PW+1)'(STORE_BASES)) begin
            status_q <= ST_FULL;
            state_q  <= S_FIN;
          end else begin
            state_q <= S_APP_WR;
          end
        end
        S_APP_WR: begin
          we_q   <= 1'b1;
          wa_q   <= used_q[AW-1:0];
          wd_q   <= app_flags;
          used_q <= used_q + CNT_W'(1);
          if (k_q == 17'd0) begin
            frag_q <= frag_q + CNT_W'(1);
          end
          if (k_q == tlen_q - 17'd1) begin
            k_q <= '0;
            c_q <= c_q + 11'd1;
            if (c_q == copies_q - 11'd1) begin
              state_q <= S_FIN;
            end
          end else begin
            k_q <= k_q + 17'd1;
          end
        end

        // cut: occlusion test at the site
        S_CUT_RD: state_q <= S_CUT_CHK;
        S_CUT_CHK: begin
          if ((rd_data & (FL_OCC5 | FL_OCC3)) != 4'b0000) begin
            status_q <= ST_OCCLUDED;
            state_q  <= S_FIN;
          end else begin
            we_q    <= 1'b1;
            wa_q    <= site_q[AW-1:0];
            wd_q    <= FL_START | FL_OCC5;
            pos_q   <= CNT_W'(site_q) + CNT_W'(1);
            i_q     <= 8'd1;
            state_q <= S_FWD_RD;
          end
        end

        // 5' occlusion run after the site
        S_FWD_RD: state_q <= S_FWD_CHK;
        S_FWD_CHK: begin
          if (i_q < occ5_q && pos_q < used_q && (rd_data & FL_OCC3) == 4'b0000) begin
            we_q    <= 1'b1;
            wa_q    <= pos_q[AW-1:0];
            wd_q    <= rd_data | FL_OCC5;
            pos_q   <= pos_q + CNT_W'(1);
            i_q     <= i_q + 8'd1;
            state_q <= S_FWD_RD;
          end else begin
            state_q <= S_BK_START;
          end
        end

        // 3' occlusion run before the site
        S_BK_START: begin
          we_q    <= 1'b1;
          wa_q    <= AW'(site_q - 16'd1);
          wd_q    <= FL_OCC3 | FL_END;
          pos_q   <= CNT_W'(site_q) - CNT_W'(1);
          i_q     <= 8'd1;
          state_q <= S_BK_STEP;
        end
        S_BK_STEP: begin
          if (i_q < occ3_q && pos_q != '0) begin
            pos_q   <= pos_q - CNT_W'(1);
            state_q <= S_BK_RD;
          end else begin
            frag_q  <= frag_q + CNT_W'(1);
            state_q <= S_FIN;
          end
        end
        S_BK_RD: state_q <= S_BK_CHK;
        S_BK_CHK: begin
          if ((rd_data & FL_OCC5) != 4'b0000) begin
            frag_q  <= frag_q + CNT_W'(1);
            state_q <= S_FIN;
          end else begin
            we_q    <= 1'b1;
            wa_q    <= pos_q[AW-1:0];
            wd_q    <= FL_OCC3;
            i_q     <= i_q + 8'd1;
            state_q <= S_BK_STEP;
          end
        end

        // scan: start flag at the pointer then walk to the end flag
        S_SC_START: begin
          pos_q <= sp_q;
          if (sp_q >= used_q) begin
            status_q <= ST_SCAN_END;
            state_q  <= S_FIN;
          end else begin
            state_q <= S_SC_RD0;
          end
        end
        S_SC_RD0: state_q <= S_SC_CHK0;
        S_SC_CHK0: begin
          if ((rd_data & FL_START) == 4'b0000) begin
            status_q <= ST_SCAN_END;
            state_q  <= S_FIN;
          end else begin
            pos_q   <= pos_q + CNT_W'(1);
            len_q   <= CNT_W'(1);
            state_q <= S_SC_TEST;
          end
        end
        S_SC_TEST: begin
          if (pos_q >= used_q) begin
            status_q <= ST_SCAN_END;
            len_q    <= '0;
            state_q  <= S_FIN;
          end else begin
            state_q <= S_SC_RD;
          end
        end
        S_SC_RD: state_q <= S_SC_CHK;
        S_SC_CHK: begin
          len_q <= len_q + CNT_W'(1);
          if ((rd_data & FL_END) != 4'b0000) begin
            sp_q    <= pos_q + CNT_W'(1);
            state_q <= S_BIN_MUL;
          end else begin
            pos_q   <= pos_q + CNT_W'(1);
            state_q <= S_SC_TEST;
          end
        end

        // bin by reciprocal of ten and length class
        S_BIN_MUL: state_q <= S_BIN_WAIT;
        S_BIN_WAIT: begin
          bin_q <= (bin_raw > BIN_W'(BIN_CAP)) ? BIN_W'(BIN_CAP) : bin_raw;
          if (MW'(len_q) < MW'(min_q)) begin
            cls_q <= 2'd0;
          end else if (MW'(len_q) > MW'(max_q)) begin
            cls_q <= 2'd2;
          end else begin
            cls_q <= 2'd1;
          end
          state_q <= S_FIN;
        end

        // mean test: used / frag <= target  <=>  used < (target + 1) * frag
        S_FIN: state_q <= S_FIN_WAIT;
        S_FIN_WAIT: begin
          reached_q <= (frag_q == '0) || (PW'(used_q) < prod);
          done_q    <= 1'b1;
          state_q   <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    result_o.status         = status_q;
    result_o.total_bases    = 17'(used_q);
    result_o.fragment_count = 17'(frag_q);
    result_o.target_reached = reached_q;
    result_o.fragment_len   = 17'(len_q);
    result_o.length_class   = cls_q;
    result_o.bin_index      = bin_q;
  end

`ifndef ASSERT_OFF
  // a result follows only from work in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without an item in progress");

  // the store never holds more than its depth
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(used_q) <= CW'(STORE_BASES))
    else $error("store fill past depth");

  // flag memory written only while an item is at work
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_q |-> $past(busy))
    else $error("flag write while idle");

  // failed scans carry no length
  a_scan_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_SCAN_END) |-> (result_o.fragment_len == 17'd0))
    else $error("scan failure with length");
`endif

endmodule

// ===== design/ofr_flag_ram.sv =====
module ofr_flag_ram import ofr_pkg::*; #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [3:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [3:0]    rdata_o
);

  logic [3:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/ofr_mul.sv =====
module ofr_mul import ofr_pkg::*; #(
  parameter int unsigned AW = 17
) (
  input  logic                  clk_i,
  input  logic [AW-1:0]         a_i,
  input  logic [MUL_B_W-1:0]    b_i,
  output logic [AW+MUL_B_W-1:0] prod_o
);

  // shared registered multiplier
  always_ff @(posedge clk_i) begin
    prod_o <= (AW+MUL_B_W)'(a_i) * (AW+MUL_B_W)'(b_i);
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import ofr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_N    = 65536;
  localparam int unsigned BIN_TOP    = 1000;
  localparam int unsigned STALL_MAX  = 200000;
  localparam int unsigned NO_STATUS  = 8;
  localparam int unsigned RAND_ITEMS = 125;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    item_i;
  logic        done_o;
  out_item_t   result_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [16:0] cfg_data_i;

  occluded_random_fragmenter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock and reset
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // mirror of the block state
  logic [3:0]  base_fl [0:STORE_N-1];
  int unsigned used_n, frag_n, scan_ptr;
  int unsigned occ5_len, occ3_len, target_len, min_len, max_len;

  out_item_t   awaited_results [$];
  int unsigned typed_status [$];
  int unsigned mismatches;
  int unsigned stall_cycles;

  // predicted result of one item, updating the mirror
  function automatic out_item_t fragmenter_step(in_item_t it);
    out_item_t   r;
    int unsigned st, flen, cls, bin, k, c, i, pos, ln, cp, site;
    logic [3:0]  f;
    bit          found;
    r = '0;
    st = ST_OK;
    flen = 0;
    cls = 0;
    bin = 0;
    ln = it.transcript_len;
    cp = it.copies;
    site = it.site_offset;
    case (it.mode)
      MODE_APPEND: begin
        if (ln < MIN_TRANSCRIPT || cp == 0) begin
          st = ST_OK;
        end else if (longint'(used_n) + longint'(ln) * longint'(cp) > longint'(STORE_N)) begin
          st = ST_FULL;
        end else begin
          for (c = 0; c < cp; c++) begin
            frag_n++;
            for (k = 0; k < ln; k++) begin
              f = '0;
              if (k == 0) f |= FL_START;
              else if (k == ln - 1) f |= FL_END;
              if (k < occ5_len) f |= FL_OCC5;
              if (k + occ3_len >= ln) f |= FL_OCC3;
              base_fl[used_n] = f;
              used_n++;
            end
          end
        end
      end
      MODE_CUT: begin
        if (site == 0 || site < occ5_len || site + occ3_len >= used_n) begin
          st = ST_RANGE;
        end else if ((base_fl[site] & (FL_OCC5 | FL_OCC3)) != 0) begin
          st = ST_OCCLUDED;
        end else begin
          base_fl[site] = FL_OCC5 | FL_START;
          // 5' run stops after occ5_len bases, at a 3' occluded base or at the end of the store
          pos = site + 1;
          i = 1;
          while (i < occ5_len && pos < used_n && (base_fl[pos] & FL_OCC3) == 0) begin
            base_fl[pos] |= FL_OCC5;
            i++;
            pos++;
          end
          // 3' run walks back up to occ3_len bases, until a 5' occluded base or base zero
          pos = site - 1;
          base_fl[pos] = FL_OCC3 | FL_END;
          i = 1;
          found = 1'b0;
          while (i < occ3_len && pos > 0 && !found) begin
            pos--;
            if ((base_fl[pos] & FL_OCC5) != 0) found = 1'b1;
            else base_fl[pos] = FL_OCC3;
            i++;
          end
          frag_n++;
        end
      end
      MODE_SCAN: begin
        if (scan_ptr >= used_n || (base_fl[scan_ptr] & FL_START) == 0) begin
          st = ST_SCAN_END;
        end else begin
          pos = scan_ptr + 1;
          ln = 1;
          found = 1'b0;
          while (pos < used_n && !found) begin
            if ((base_fl[pos] & FL_END) != 0) begin
              found = 1'b1;
            end else begin
              ln++;
              pos++;
            end
          end
          if (!found) begin
            st = ST_SCAN_END;
          end else begin
            ln++;
            scan_ptr = pos + 1;
            flen = ln;
            cls = (ln < min_len) ? 0 : ((ln > max_len) ? 2 : 1);
            bin = ((ln > BIN_CLAMP) ? BIN_CLAMP : ln) / 10;
            if (bin > BIN_TOP) bin = BIN_TOP;
          end
        end
      end
      default: ;
    endcase
    r.status         = st[2:0];
    r.total_bases    = used_n[16:0];
    r.fragment_count = frag_n[16:0];
    r.target_reached = (frag_n == 0) ? 1'b1 : ((used_n / frag_n) <= target_len);
    r.fragment_len   = flen[16:0];
    r.length_class   = cls[1:0];
    r.bin_index      = bin[9:0];
    return r;
  endfunction

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
      mismatches++;
    end
  endfunction

  // accepted items go to the predictor, strobed results are checked
  always @(posedge clk_i) begin
    out_item_t   want;
    int unsigned typed;
    if (rst_ni) begin
      if (done_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("unexpected result", 0, 1);
        end else begin
          want = awaited_results.pop_front();
          note_mismatch("status", want.status, result_o.status);
          note_mismatch("total_bases", want.total_bases, result_o.total_bases);
          note_mismatch("fragment_count", want.fragment_count, result_o.fragment_count);
          note_mismatch("target_reached", want.target_reached, result_o.target_reached);
          note_mismatch("fragment_len", want.fragment_len, result_o.fragment_len);
          note_mismatch("length_class", want.length_class, result_o.length_class);
          note_mismatch("bin_index", want.bin_index, result_o.bin_index);
        end
      end
      if (start && !busy) begin
        want = fragmenter_step(item_i);
        typed = (typed_status.size() != 0) ? typed_status.pop_front() : NO_STATUS;
        if (typed != NO_STATUS) note_mismatch("table status", typed, want.status);
        awaited_results.push_back(want);
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[16:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_OCC5:   occ5_len = val & 8'hFF;
      REG_OCC3:   occ3_len = val & 8'hFF;
      REG_TARGET: target_len = val & 17'h1FFFF;
      REG_MIN:    min_len = val & 17'h1FFFF;
      REG_MAX:    max_len = val & 17'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // present one item after an optional gap, return at its acceptance edge
  task automatic send_item(in_item_t it, int unsigned gap, int unsigned st_typed);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_status.push_back(st_typed);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r, s;
    it = in_item_t'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < 30) begin
      it.mode = MODE_APPEND;
      if (s < 85) begin
        it.transcript_len = $urandom_range(20, 200);
        it.copies = $urandom_range(1, 3);
      end else if (s < 92) begin
        it.transcript_len = $urandom_range(0, 19);
        it.copies = $urandom_range(0, 3);
      end else if (s < 95) begin
        it.transcript_len = $urandom_range(20, 200);
        it.copies = 0;
      end else begin
        // oversized: refused as the store cannot hold it, but one copy of 65536 fits an empty store
        it.transcript_len[16] = 1'b1;
        if (it.copies == 0) it.copies = 1;
      end
    end else if (r < 70) begin
      it.mode = MODE_CUT;
      if (s < 90) begin
        s = $urandom_range(0, used_n + 10);
        it.site_offset = s[15:0];
      end
    end else if (r < 95) begin
      it.mode = MODE_SCAN;
    end else begin
      it.mode = 2'd3;
    end
    return it;
  endfunction

  // directed rows: mode, length, copies, site, status where obvious
  typedef struct {
    logic [1:0]  mode;
    int unsigned tlen;
    int unsigned copies;
    int unsigned site;
    int unsigned st;
  } row_t;

  row_t rows [] = '{
    '{MODE_SCAN,   0,      0,    0,     ST_SCAN_END},
    '{MODE_CUT,    0,      0,    5,     ST_RANGE},
    '{MODE_APPEND, 19,     1,    0,     ST_OK},
    '{MODE_APPEND, 20,     0,    0,     ST_OK},
    '{MODE_APPEND, 65536,  2047, 0,     ST_FULL},
    '{MODE_APPEND, 131071, 1,    0,     ST_FULL},
    '{MODE_APPEND, 20,     1,    0,     ST_OK},
    '{MODE_APPEND, 300,    2,    65535, ST_OK},
    '{2'd3,        131071, 2047, 65535, ST_OK},
    '{MODE_CUT,    0,      0,    0,     ST_RANGE},
    '{MODE_CUT,    0,      0,    65535, ST_RANGE},
    '{MODE_CUT,    0,      0,    19,    NO_STATUS},
    '{MODE_CUT,    0,      0,    20,    NO_STATUS},
    '{MODE_CUT,    0,      0,    20,    NO_STATUS},
    '{MODE_CUT,    0,      0,    100,   NO_STATUS},
    '{MODE_CUT,    0,      0,    619,   NO_STATUS},
    '{MODE_SCAN,   0,      0,    0,     NO_STATUS},
    '{MODE_SCAN,   0,      0,    0,     NO_STATUS},
    '{MODE_SCAN,   0,      0,    0,     NO_STATUS},
    '{MODE_SCAN,   0,      0,    0,     NO_STATUS},
    '{MODE_SCAN,   0,      0,    0,     NO_STATUS},
    '{MODE_SCAN,   0,      0,    0,     NO_STATUS},
    '{MODE_SCAN,   0,      0,    0,     NO_STATUS}
  };

  // register settings per phase: occ5, occ3, target, min, max
  int unsigned phase_cfg [5][5] = '{
    '{3,   5,   150,   50,    300},
    '{255, 255, 1,     0,     65536},
    '{0,   255, 65536, 65536, 0},
    '{255, 0,   40,    100,   1000},
    '{0,   0,   0,     0,     0}
  };

  initial begin
    in_item_t    it;
    int unsigned p, n, g;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    item_i     <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_OCC5;
    cfg_data_i <= '0;
    used_n = 0;
    frag_n = 0;
    scan_ptr = 0;
    occ5_len = 0;
    occ3_len = 0;
    target_len = 200;
    min_len = 0;
    max_len = 65536;
    mismatches = 0;
    stall_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings
    foreach (rows[j]) begin
      it = '0;
      it.mode = rows[j].mode;
      it.transcript_len = rows[j].tlen[16:0];
      it.copies = rows[j].copies[10:0];
      it.site_offset = rows[j].site[15:0];
      send_item(it, pick_gap(1'b0), rows[j].st);
    end
    drain_results();

    // random phases, each under new register settings
    for (p = 0; p < 5; p++) begin
      if (p == 4) begin
        phase_cfg[4][0] = $urandom_range(0, 20);
        phase_cfg[4][1] = $urandom_range(0, 20);
        phase_cfg[4][2] = $urandom_range(1, 400);
        phase_cfg[4][3] = $urandom_range(0, 200);
        phase_cfg[4][4] = $urandom_range(100, 65536);
      end
      write_reg(REG_OCC5,   phase_cfg[p][0]);
      write_reg(REG_OCC3,   phase_cfg[p][1]);
      write_reg(REG_TARGET, phase_cfg[p][2]);
      write_reg(REG_MIN,    phase_cfg[p][3]);
      write_reg(REG_MAX,    phase_cfg[p][4]);
      for (n = 0; n < RAND_ITEMS; n++) begin
        // sender holds off until the block has answered everything
        if (n == 40) drain_results();
        g = pick_gap(n >= 60 && n < 90);
        send_item(random_item(), g, NO_STATUS);
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (awaited_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ofr_pkg.sv
design/ofr_flag_ram.sv
design/ofr_mul.sv
design/occluded_random_fragmenter.sv
bench/tb_top.sv
